// ===== rtl/pitip_pkg.sv =====
// ----------------------------------------------------------------------------
// pitip_pkg
// shared types and constants of the turn-in-place pi controller
// ----------------------------------------------------------------------------
package pitip_pkg;

   // field and state widths
   localparam int YAW_W   = 9;
   localparam int TURN_W  = 10;
   localparam int ERR_W   = 13;
   localparam int VEL_W   = 14;
   localparam int INTEG_W = 28;
   localparam int DRIVE_W = 9;
   localparam int DEN_W   = 27;

   // heading wrap band near 0/360
   localparam logic [YAW_W-1:0] WRAP_LO = 9'd30;
   localparam logic [YAW_W-1:0] WRAP_HI = 9'd330;
   localparam logic signed [ERR_W-1:0] FULL_TURN = 13'sd360;

   // error clamp and done window
   localparam logic signed [ERR_W-1:0] ERR_MAX  = 13'sd4095;
   localparam logic signed [ERR_W-1:0] ERR_MIN  = -13'sd4096;
   localparam logic signed [ERR_W-1:0] DONE_HI  = 13'sd1;
   localparam logic signed [ERR_W-1:0] DONE_LO  = -13'sd1;

   // stiction offsets (magnitudes) and drive limit
   localparam logic [7:0] STIC_POS   = 8'd70;
   localparam logic [7:0] STIC_NEG_L = 8'd75;
   localparam logic [7:0] STIC_NEG_R = 8'd70;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd170;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd170;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic step_err;
      logic step_sq;
      logic div_start;
      logic step_mul;
      logic step_int;
      logic step_u;
      logic step_lr;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
   } sts_type;

endpackage

// ===== rtl/pi_turn_in_place_controller_core.sv =====
// ----------------------------------------------------------------------------
// pi_turn_in_place_controller_core
// pi heading controller for turning a two-wheel robot in place
// ----------------------------------------------------------------------------
// req channel: one beat per yaw sample, yaw in tdata, new-turn flag in tuser.
// rsp channel: one beat per sample, left/right drive in tdata, done in tuser.
// csr channel: writes the signed turn angle; always ready, take it while idle.
// each beat runs through a sequencer: error step, square, an iterative
// divider for the stiction factor (one quotient bit a cycle), then
// multiply, integrate, sum and drive steps. one beat is processed at a
// time, so a new beat is taken only once the last one has gone through
// the drive steps and into the output register.
// the result sits in an output register; a stalled receiver holds it there,
// and the next sample is accepted and worked on meanwhile, waiting only
// before the output register if it is still full.
// reset clears the turn state and the turn angle; the first sample after
// reset starts a turn.
// ----------------------------------------------------------------------------
module pi_turn_in_place_controller_core #(
   parameter int FRACTION_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // yaw sample beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] yaw_deg
   input  logic        req_tuser,   // [0] new_turn
   // drive result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [8:0] left_drive, [17:9] right_drive
   output logic        rsp_tuser,   // [0] turn_done
   // turn angle write
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // [9:0] turn_degrees
);

   pitip_pkg::cmd_type cmd;
   pitip_pkg::sts_type sts;
   logic signed [pitip_pkg::DRIVE_W-1:0] left_drive, right_drive;
   logic turn_done;

   assign csr_tready = 1'b1;

   // sequencer
   pitip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // arithmetic and turn state
   pitip_dpath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_tvalid && csr_tready),
      .csr_turn    (csr_tdata[pitip_pkg::TURN_W-1:0]),
      .in_new_turn (req_tuser),
      .in_yaw      (req_tdata[pitip_pkg::YAW_W-1:0]),
      .out_left    (left_drive),
      .out_right   (right_drive),
      .out_done    (turn_done)
   );

   // result packing
   assign rsp_tdata = {6'b0, right_drive, left_drive};
   assign rsp_tuser = turn_done;

endmodule

// ===== rtl/pitip_div.sv =====
// ----------------------------------------------------------------------------
// pitip_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pitip_div #(
   parameter int QW = 13,
   parameter int DW = 27
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW:0]   trial;
   logic          fits;

   // one shift-and-subtract step
   assign trial = {rem_ff, num_ff[QW-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rem_in  = '0;
         num_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, divisor}) : DW'(trial);
         num_in = {num_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/pitip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pitip_ctrl
// sequencer for one yaw beat: error, divide, integrate, drive, output
// ----------------------------------------------------------------------------
module pitip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output pitip_pkg::cmd_type cmd,
   input  pitip_pkg::sts_type sts
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ERR  = 4'd1;
   localparam logic [3:0] ST_SQ   = 4'd2;
   localparam logic [3:0] ST_DIVS = 4'd3;
   localparam logic [3:0] ST_DIVW = 4'd4;
   localparam logic [3:0] ST_MUL  = 4'd5;
   localparam logic [3:0] ST_INT  = 4'd6;
   localparam logic [3:0] ST_U    = 4'd7;
   localparam logic [3:0] ST_LR   = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       out_free;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.step_err = 1'b1;
            state_in     = ST_SQ;
         end
         ST_SQ: begin
            cmd.step_sq = 1'b1;
            state_in    = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (sts.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = ST_INT;
         end
         ST_INT: begin
            cmd.step_int = 1'b1;
            state_in     = ST_U;
         end
         ST_U: begin
            cmd.step_u = 1'b1;
            state_in   = ST_LR;
         end
         ST_LR: begin
            cmd.step_lr = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid: set on load, cleared when taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (cmd.load_out) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_vld_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   // divider finishes only while the sequencer waits for it
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIVW))
      else $error("divider done outside wait state");

   // an accepted beat starts the error step next
   a_accept_err: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ERR))
      else $error("accepted beat did not start processing");

endmodule

// ===== rtl/pitip_dpath.sv =====
// ----------------------------------------------------------------------------
// pitip_dpath
// turn state, error, stiction factor, integrator and drive arithmetic
// ----------------------------------------------------------------------------
module pitip_dpath #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pitip_pkg::cmd_type                        cmd,
   output pitip_pkg::sts_type                        sts,
   input  logic                                      csr_we,
   input  logic [pitip_pkg::TURN_W-1:0]              csr_turn,
   input  logic                                      in_new_turn,
   input  logic [pitip_pkg::YAW_W-1:0]               in_yaw,
   output logic signed [pitip_pkg::DRIVE_W-1:0]      out_left,
   output logic signed [pitip_pkg::DRIVE_W-1:0]      out_right,
   output logic                                      out_done
);

   localparam int F    = FRACTION_BITS;
   localparam int EW   = pitip_pkg::ERR_W;
   localparam int IW   = pitip_pkg::INTEG_W;
   localparam int SW   = F + 1;                   // stiction factor, max 2^F
   localparam int SMW  = F + 8;                   // factor times offset
   localparam int PW   = EW + F + 2;              // error products
   localparam int SUMW = ((PW > IW) ? PW : IW) + 1;
   localparam int LW   = SUMW + 1;
   localparam int KP   = ((9 << F) + 5) / 10;
   localparam logic [SW-1:0] ONE_FX = {1'b1, {F{1'b0}}};
   localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

   // configuration and input beat
   logic [pitip_pkg::TURN_W-1:0] turn_ff;
   logic                         nt_ff;
   logic [pitip_pkg::YAW_W-1:0]  yaw_ff;

   // turn state
   logic                         started_ff;
   logic [pitip_pkg::YAW_W-1:0]  pyaw_ff;
   logic signed [EW-1:0]         goal_ff;
   logic signed [EW-1:0]         perr_ff;
   logic signed [IW-1:0]         integ_ff;

   // per-beat working registers
   logic signed [EW-1:0]                 err_ff;
   logic signed [pitip_pkg::VEL_W-1:0]   vel_ff;
   logic                                 done_ff;
   logic [pitip_pkg::DEN_W-1:0]          den_ff;
   logic signed [PW-1:0]                 isp_ff;
   logic signed [PW-1:0]                 kpe_ff;
   logic [SMW-1:0]                       sp_ff, snl_ff, snr_ff;
   logic signed [SUMW-1:0]               u_ff;
   logic signed [LW-1:0]                 left_ff, right_ff;

   // result payload
   logic signed [pitip_pkg::DRIVE_W-1:0] lout_ff, rout_ff;
   logic                                 dout_ff;

   // error step signals
   logic                         start;
   logic signed [EW-1:0]         start_goal, base_goal, goal_nxt, base_perr, err_c;
   logic [pitip_pkg::YAW_W-1:0]  base_pyaw;
   logic                         wrap_dn, wrap_up, sign_chg, done_c;
   logic signed [EW:0]           diff;

   // later steps
   logic [SW-1:0]                s_q;
   logic signed [SW:0]           s_sg;
   logic signed [SW:0]           kp_sg;
   logic [SMW-1:0]               s_ext;
   logic signed [2*pitip_pkg::VEL_W-1:0] vsq;
   logic signed [PW-1:0]         istep;
   logic signed [SUMW-1:0]       isum;
   logic signed [IW-1:0]         integ_sat;
   logic signed [LW-1:0]         u_w, sp_w, snl_w, snr_w;
   logic signed [LW-1:0]         lb, rb, ls, rs;
   logic signed [pitip_pkg::DRIVE_W-1:0] lclamp, rclamp;

   // start of turn and heading wrap
   always_comb begin
      start      = nt_ff || !started_ff;
      start_goal = $signed({4'b0, yaw_ff}) + EW'($signed(turn_ff));
      base_goal  = start ? start_goal : goal_ff;
      base_pyaw  = start ? yaw_ff : pyaw_ff;
      base_perr  = start ? '0 : perr_ff;
      wrap_dn    = (base_pyaw > pitip_pkg::WRAP_HI) && (yaw_ff < pitip_pkg::WRAP_LO);
      wrap_up    = (base_pyaw < pitip_pkg::WRAP_LO) && (yaw_ff > pitip_pkg::WRAP_HI);
      if (wrap_dn) begin
         goal_nxt = base_goal - pitip_pkg::FULL_TURN;
      end else if (wrap_up) begin
         goal_nxt = base_goal + pitip_pkg::FULL_TURN;
      end else begin
         goal_nxt = base_goal;
      end
   end

   // clamped error, sign change and done window
   always_comb begin
      diff = (EW+1)'(goal_nxt) - (EW+1)'($signed({1'b0, yaw_ff}));
      if (diff < (EW+1)'(pitip_pkg::ERR_MIN)) begin
         err_c = pitip_pkg::ERR_MIN;
      end else if (diff > (EW+1)'(pitip_pkg::ERR_MAX)) begin
         err_c = pitip_pkg::ERR_MAX;
      end else begin
         err_c = diff[EW-1:0];
      end
      sign_chg = ((err_c < 0) && (base_perr > 0)) || ((err_c > 0) && (base_perr < 0));
      done_c   = (err_c >= pitip_pkg::DONE_LO) && (err_c <= pitip_pkg::DONE_HI) &&
                 (base_perr >= pitip_pkg::DONE_LO) && (base_perr <= pitip_pkg::DONE_HI);
   end

   // stiction factor 2^F / (1 + vel^2)
   pitip_div #(
      .QW (SW),
      .DW (pitip_pkg::DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ONE_FX),
      .divisor  (den_ff),
      .done     (sts.div_done),
      .quotient (s_q)
   );

   assign vsq   = vel_ff * vel_ff;
   assign s_sg  = $signed({1'b0, s_q});
   assign kp_sg = (SW+1)'(KP);
   assign s_ext = SMW'(s_q);

   // integral step truncated toward zero, saturating sum
   always_comb begin
      istep = (isp_ff + ((isp_ff < 0) ? PW'(3) : PW'(0))) >>> 2;
      isum  = SUMW'(integ_ff) + SUMW'(istep);
      if (isum > SUMW'(IMAX)) begin
         integ_sat = IMAX;
      end else if (isum < SUMW'(IMIN)) begin
         integ_sat = IMIN;
      end else begin
         integ_sat = isum[IW-1:0];
      end
   end

   // drive terms
   assign u_w   = LW'(u_ff);
   assign sp_w  = LW'($signed({1'b0, sp_ff}));
   assign snl_w = LW'($signed({1'b0, snl_ff}));
   assign snr_w = LW'($signed({1'b0, snr_ff}));

   // divide by 2^F toward zero, then clamp
   always_comb begin
      lb = left_ff  + ((left_ff  < 0) ? LW'((1 << F) - 1) : LW'(0));
      rb = right_ff + ((right_ff < 0) ? LW'((1 << F) - 1) : LW'(0));
      ls = lb >>> F;
      rs = rb >>> F;
      if (ls > LW'(pitip_pkg::DRIVE_MAX)) begin
         lclamp = pitip_pkg::DRIVE_MAX;
      end else if (ls < LW'(pitip_pkg::DRIVE_MIN)) begin
         lclamp = pitip_pkg::DRIVE_MIN;
      end else begin
         lclamp = ls[pitip_pkg::DRIVE_W-1:0];
      end
      if (rs > LW'(pitip_pkg::DRIVE_MAX)) begin
         rclamp = pitip_pkg::DRIVE_MAX;
      end else if (rs < LW'(pitip_pkg::DRIVE_MIN)) begin
         rclamp = pitip_pkg::DRIVE_MIN;
      end else begin
         rclamp = rs[pitip_pkg::DRIVE_W-1:0];
      end
   end

   // turn angle register and turn state
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff    <= '0;
         started_ff <= 1'b0;
         pyaw_ff    <= '0;
         goal_ff    <= '0;
         perr_ff    <= '0;
         integ_ff   <= '0;
      end else begin
         if (csr_we) begin
            turn_ff <= csr_turn;
         end
         if (cmd.step_err) begin
            started_ff <= 1'b1;
            pyaw_ff    <= yaw_ff;
            goal_ff    <= goal_nxt;
            perr_ff    <= done_c ? base_perr : err_c;
            integ_ff   <= (start || sign_chg) ? '0 : integ_ff;
         end else if (cmd.step_int && !done_ff) begin
            integ_ff <= integ_sat;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         nt_ff  <= in_new_turn;
         yaw_ff <= in_yaw;
      end
      if (cmd.step_err) begin
         err_ff  <= err_c;
         vel_ff  <= (pitip_pkg::VEL_W)'(err_c) - (pitip_pkg::VEL_W)'(base_perr);
         done_ff <= done_c;
      end
      if (cmd.step_sq) begin
         den_ff <= (pitip_pkg::DEN_W)'(vsq) + 1'b1;
      end
      if (cmd.step_mul) begin
         isp_ff <= err_ff * s_sg;
         kpe_ff <= err_ff * kp_sg;
         sp_ff  <= s_ext * SMW'(pitip_pkg::STIC_POS);
         snl_ff <= s_ext * SMW'(pitip_pkg::STIC_NEG_L);
         snr_ff <= s_ext * SMW'(pitip_pkg::STIC_NEG_R);
      end
      if (cmd.step_u) begin
         u_ff <= SUMW'(kpe_ff) + SUMW'(integ_ff);
      end
      if (cmd.step_lr) begin
         left_ff  <= u_w + ((u_ff > 0) ? sp_w : -snl_w);
         right_ff <= -u_w + ((u_ff < 0) ? sp_w : -snr_w);
      end
      if (cmd.load_out) begin
         lout_ff <= done_ff ? '0 : lclamp;
         rout_ff <= done_ff ? '0 : rclamp;
         dout_ff <= done_ff;
      end
   end

   assign out_left  = lout_ff;
   assign out_right = rout_ff;
   assign out_done  = dout_ff;

endmodule

// ===== verif/pi_turn_in_place_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// pi_turn_in_place_controller_core_test
// self-checking bench for the turn-in-place pi controller core
// ----------------------------------------------------------------------------
// yaw sample beats go in on the req stream and every sample is predicted with
// a bit-true copy of the controller: goal capture, wrap shift, sign-change
// clear, stiction factor, saturating integrator, drive clamp and done window.
// drive beats from the rsp stream are compared field by field in order.
// phases change the turn angle between runs and mix sender gaps and receiver
// stalls; the random part is mostly realistic turns and full spins, with
// stray samples and broken turns mixed in.
// ----------------------------------------------------------------------------
module pi_turn_in_place_controller_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 12;
   localparam int CLK_HALF    = 10;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 2 * (FRAC + 10);
   localparam int PHASE_BEATS = 115;

   // controller constants
   localparam int     BAND_LO     = 30;
   localparam int     BAND_HI     = 330;
   localparam int     FULL_CIRCLE = 360;
   localparam longint ERR_HI      = 4095;
   localparam longint ERR_LO      = -4096;
   localparam longint INTEG_HI    = 134217727;
   localparam longint INTEG_LO    = -134217728;
   localparam longint PUSH_FWD    = 70;
   localparam longint PUSH_BACK_L = 75;
   localparam longint PUSH_BACK_R = 70;
   localparam longint DRIVE_LIM   = 170;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [pitip_pkg::DRIVE_W-1:0] left_drive;
      logic signed [pitip_pkg::DRIVE_W-1:0] right_drive;
      logic                                 turn_done;
   } drive_beat_type;

   // predicts drive beats from yaw samples and checks them in order
   class drive_checker;
      logic signed [pitip_pkg::TURN_W-1:0] turn_deg;
      bit                                  started;
      logic [pitip_pkg::YAW_W-1:0]         last_yaw;
      logic signed [pitip_pkg::ERR_W-1:0]  goal;
      longint                              last_err;
      longint                              integ;
      drive_beat_type                      due[$];
      int                                  failures;

      function new();
         turn_deg = '0;
         started  = 1'b0;
         last_yaw = '0;
         goal     = '0;
         last_err = 0;
         integ    = 0;
         failures = 0;
      endfunction

      function void set_turn(logic signed [pitip_pkg::TURN_W-1:0] angle);
         turn_deg = angle;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // note an accepted yaw sample and queue the drive it must produce
      function void take_sample(bit new_turn, logic [pitip_pkg::YAW_W-1:0] yaw);
         longint         yaw_v, err, vel, s, kp, u, left, right;
         drive_beat_type beat;
         yaw_v = longint'(yaw);
         // turn start: capture goal, clear integrator and history
         if (new_turn || !started) begin
            last_yaw = yaw;
            goal     = 13'(yaw_v + longint'(turn_deg));
            integ    = 0;
            last_err = 0;
            started  = 1'b1;
         end
         // shift goal when the heading wraps across 0/360
         if (last_yaw > BAND_HI && yaw < BAND_LO)
            goal = 13'(longint'(goal) - FULL_CIRCLE);
         else if (last_yaw < BAND_LO && yaw > BAND_HI)
            goal = 13'(longint'(goal) + FULL_CIRCLE);
         last_yaw = yaw;
         err = clip(longint'(goal) - yaw_v, ERR_LO, ERR_HI);
         // error sign flip clears the integrator
         if ((err < 0 && last_err > 0) || (err > 0 && last_err < 0))
            integ = 0;
         vel = err - last_err;
         s   = (longint'(1) <<< FRAC) / (1 + vel * vel);
         if (err >= -1 && err <= 1 && last_err >= -1 && last_err <= 1) begin
            beat.left_drive  = '0;
            beat.right_drive = '0;
            beat.turn_done   = 1'b1;
         end else begin
            last_err = err;
            integ    = clip(integ + (err * s) / 4, INTEG_LO, INTEG_HI);
            kp       = ((longint'(9) <<< FRAC) + 5) / 10;
            u        = kp * err + integ;
            left     = u + s * ((u > 0) ? PUSH_FWD : -PUSH_BACK_L);
            right    = -u + s * ((u < 0) ? PUSH_FWD : -PUSH_BACK_R);
            beat.left_drive  = 9'(clip(left / (longint'(1) <<< FRAC), -DRIVE_LIM, DRIVE_LIM));
            beat.right_drive = 9'(clip(right / (longint'(1) <<< FRAC), -DRIVE_LIM, DRIVE_LIM));
            beat.turn_done   = 1'b0;
         end
         due.push_back(beat);
      endfunction

      // compare one drive beat against the oldest prediction
      function void check_drive(logic [8:0] left, logic [8:0] right, logic done);
         drive_beat_type beat;
         if (due.size() == 0) begin
            $error("drive beat with no yaw sample pending");
            failures++;
            return;
         end
         beat = due.pop_front();
         if (left !== beat.left_drive) begin
            $error("left_drive expected %0d got %0d", beat.left_drive, $signed(left));
            failures++;
         end
         if (right !== beat.right_drive) begin
            $error("right_drive expected %0d got %0d", beat.right_drive, $signed(right));
            failures++;
         end
         if (done !== beat.turn_done) begin
            $error("turn_done expected %0d got %0d", beat.turn_done, done);
            failures++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [8:0] yaw_deg
   logic        req_tuser  = 1'b0; // [0] new_turn
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [8:0] left_drive, [17:9] right_drive
   logic        rsp_tuser;         // [0] turn_done
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata  = '0;   // [9:0] turn_degrees

   drive_checker board;
   int           gap_pct      = 0;
   int           stall_pct    = 0;
   int           cur_turn     = 0;
   int           phase_beats  = 0;
   int           quiet_cycles = 0;

   pi_turn_in_place_controller_core #(
      .FRACTION_BITS(FRAC)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #CLK_HALF clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_drive(rsp_tdata[8:0], rsp_tdata[17:9], rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
             || (csr_tvalid && csr_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic int wrap_deg(int v);
      return ((v % FULL_CIRCLE) + FULL_CIRCLE) % FULL_CIRCLE;
   endfunction

   function automatic void set_idle(idle_mode_type mode);
      case (mode)
         IDLE_SEND: begin gap_pct = 51; stall_pct = 0;  end
         IDLE_RECV: begin gap_pct = 0;  stall_pct = 51; end
         IDLE_BOTH: begin gap_pct = 12; stall_pct = 12; end
         default:   begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endfunction

   // one yaw beat, with optional sender gaps ahead of it
   task automatic send_heading(input bit new_turn, input logic [8:0] yaw);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, yaw};
      req_tuser  <= new_turn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_sample(new_turn, yaw);
      phase_beats++;
   endtask

   // turn angle write, only while the core is idle
   task automatic write_turn_angle(input int angle);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {6'd0, 10'(angle)};
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      board.set_turn(10'(angle));
      cur_turn = angle;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // stop sending and let every pending drive beat come out
   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // a realistic turn: start, walk toward the goal, settle with jitter
   task automatic run_turn_sequence();
      int start_yaw, heading, aim, step, moves;
      start_yaw = $urandom_range(0, 359);
      aim       = start_yaw + cur_turn;
      heading   = start_yaw;
      moves     = 0;
      send_heading(1'b1, start_yaw);
      while (heading != aim && moves < 80) begin
         step = $urandom_range(1, 25);
         if (aim > heading)
            heading += (step < aim - heading) ? step : aim - heading;
         else
            heading -= (step < heading - aim) ? step : heading - aim;
         // stray samples, now and then a restart in mid-turn
         if ($urandom_range(9) == 0)
            send_heading($urandom_range(7) == 0, $urandom_range(0, 511));
         else
            send_heading(1'b0, wrap_deg(heading));
         moves++;
      end
      repeat ($urandom_range(2, 5))
         send_heading(1'b0, wrap_deg(aim + int'($urandom_range(0, 2)) - 1));
   endtask

   // full spins can push the goal past the 13 bit range, and a hold can saturate
   task automatic run_spin_sequence();
      int pat[4];
      int revs;
      revs = $urandom_range(10, 14);
      if ($urandom_range(1) == 1)
         pat = '{10, 340, 230, 120};
      else
         pat = '{340, 10, 120, 230};
      send_heading(1'b1, pat[0]);
      for (int i = 1; i <= 4 * revs; i++)
         send_heading(1'b0, pat[i % 4]);
      repeat ($urandom_range(0, 40))
         send_heading(1'b0, pat[0]);
   endtask

   task automatic run_phase(input int angle, input idle_mode_type mode);
      write_turn_angle(angle);
      set_idle(mode);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
         if ($urandom_range(5) == 0)
            run_spin_sequence();
         else
            run_turn_sequence();
      end
      finish_phase();
   endtask

   initial begin
      int angle;
      board = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first sample starts a turn, approach, done window, overshoot
      set_idle(IDLE_NONE);
      write_turn_angle(90);
      send_heading(1'b0, 0);
      send_heading(1'b0, 20);
      send_heading(1'b0, 60);
      send_heading(1'b0, 85);
      send_heading(1'b0, 89);
      send_heading(1'b0, 90);
      send_heading(1'b0, 91);
      send_heading(1'b0, 92);
      send_heading(1'b0, 100);
      // wrap forward and back across north
      send_heading(1'b1, 345);
      send_heading(1'b0, 5);
      send_heading(1'b0, 340);
      // yaw outside 0..359 and bit patterns
      send_heading(1'b1, 511);
      send_heading(1'b0, 256);
      send_heading(1'b0, 255);
      send_heading(1'b1, 0);
      send_heading(1'b0, 359);
      send_heading(1'b0, 0);
      // settle right on the goal
      send_heading(1'b1, 200);
      send_heading(1'b0, 290);
      send_heading(1'b0, 290);
      send_heading(1'b0, 400);
      finish_phase();

      // random phases over extreme and random turn angles
      run_phase(-512, IDLE_SEND);
      run_phase(511, IDLE_RECV);
      run_phase(-360, IDLE_BOTH);
      run_phase(360, IDLE_NONE);
      run_phase(0, IDLE_SEND);
      for (int p = 0; p < 3; p++) begin
         angle = $urandom_range(0, 1023);
         if (angle > 511) angle -= 1024;
         run_phase(angle, idle_mode_type'((p + 2) % 4));
      end

      if (board.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
